>>> rtl/lcg_ja_pkg.sv
`timescale 1ns / 1ps

package lcg_ja_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LANES   = 4;
  localparam int unsigned ROUNDS  = 32;
  localparam int unsigned CNT_W   = $clog2(ROUNDS);

  localparam logic [WORD_W-1:0] LCG_MUL = 32'h0003_43FD;
  localparam logic [WORD_W-1:0] LCG_INC = 32'h0026_9EC3;

  typedef logic [WORD_W-1:0] word_t;

  // lane assignment of the shared multiply unit
  localparam int unsigned LN_ACC_MUL = 0;  // acc_mul * cur_mul, or acc_mul * seed at the end
  localparam int unsigned LN_ACC_INC = 1;  // acc_inc * cur_mul
  localparam int unsigned LN_CUR_INC = 2;  // (cur_mul + 1) * cur_inc
  localparam int unsigned LN_CUR_MUL = 3;  // cur_mul * cur_mul

  typedef struct packed {
    word_t [LANES-1:0] a;
    word_t [LANES-1:0] b;
  } mul_ops_t;

  typedef word_t [LANES-1:0] mul_res_t;

  typedef struct packed {
    logic load;   // capture a new request
    logic iter;   // one square-and-multiply round
    logic fin;    // apply accumulated map to seed
  } ctrl_t;

endpackage

>>> rtl/lcg_ja_mul.sv
`timescale 1ns / 1ps

// Shared multiply unit: four lanes, low word of each product.
module lcg_ja_mul (
  input  lcg_ja_pkg::mul_ops_t ops,
  output lcg_ja_pkg::mul_res_t prod
);

  always_comb begin
    for (int i = 0; i < lcg_ja_pkg::LANES; i++) begin
      prod[i] = ops.a[i] * ops.b[i];
    end
  end

endmodule

>>> rtl/lcg_ja_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: idle -> 32 rounds -> final multiply -> idle.
module lcg_ja_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output lcg_ja_pkg::ctrl_t    ctrl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ITER = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [lcg_ja_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          last_round;

  assign last_round = (cnt_r == lcg_ja_pkg::CNT_W'(lcg_ja_pkg::ROUNDS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        ctrl.iter = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (last_round) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        ctrl.fin  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/lcg_jump_ahead.sv
`timescale 1ns / 1ps

// Channel    Ports                                   Handshake
// ---------  --------------------------------------  ------------------------------
// request    in_start_seed, in_step_count            taken when start && !busy
// result     out_advanced_seed                       valid for one cycle on out_valid
//
// A request passes from the accepting edge to the result strobe through
// 32 square-and-multiply rounds (one bit of the step count each, on the
// four-lane shared multiplier) plus one final seed multiply and one output
// register. A new request may be accepted in the cycle the result shows.
// Reset (synchronous, active low) returns the sequencer to idle and clears
// out_valid. The receiver cannot stall; each result is shown once.
module lcg_jump_ahead (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [31:0]               in_start_seed,
  input  logic [31:0]               in_step_count,
  output logic                      out_valid,
  output logic [31:0]               out_advanced_seed
);

  lcg_ja_pkg::ctrl_t     ctrl;
  lcg_ja_pkg::mul_ops_t  ops;
  lcg_ja_pkg::mul_res_t  prod;

  // request and working registers (payload, no reset needed)
  lcg_ja_pkg::word_t seed_r,    seed_nxt;
  lcg_ja_pkg::word_t steps_r,   steps_nxt;
  lcg_ja_pkg::word_t acc_mul_r, acc_mul_nxt;   // accumulated map: x -> acc_mul*x + acc_inc
  lcg_ja_pkg::word_t acc_inc_r, acc_inc_nxt;
  lcg_ja_pkg::word_t cur_mul_r, cur_mul_nxt;   // map for the current power-of-two jump
  lcg_ja_pkg::word_t cur_inc_r, cur_inc_nxt;
  lcg_ja_pkg::word_t res_r,     res_nxt;
  logic              vld_r,     vld_nxt;

  lcg_ja_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // operand steering for the shared multiplier
  always_comb begin
    ops.a[lcg_ja_pkg::LN_ACC_MUL] = acc_mul_r;
    ops.b[lcg_ja_pkg::LN_ACC_MUL] = ctrl.fin ? seed_r : cur_mul_r;
    ops.a[lcg_ja_pkg::LN_ACC_INC] = acc_inc_r;
    ops.b[lcg_ja_pkg::LN_ACC_INC] = cur_mul_r;
    ops.a[lcg_ja_pkg::LN_CUR_INC] = cur_mul_r + 32'd1;
    ops.b[lcg_ja_pkg::LN_CUR_INC] = cur_inc_r;
    ops.a[lcg_ja_pkg::LN_CUR_MUL] = cur_mul_r;
    ops.b[lcg_ja_pkg::LN_CUR_MUL] = cur_mul_r;
  end

  lcg_ja_mul u_mul (
    .ops  (ops),
    .prod (prod)
  );

  always_comb begin
    seed_nxt    = seed_r;
    steps_nxt   = steps_r;
    acc_mul_nxt = acc_mul_r;
    acc_inc_nxt = acc_inc_r;
    cur_mul_nxt = cur_mul_r;
    cur_inc_nxt = cur_inc_r;
    res_nxt     = res_r;
    vld_nxt     = 1'b0;

    if (ctrl.load) begin
      // identity accumulator, single-step map as the first jump
      seed_nxt    = in_start_seed;
      steps_nxt   = in_step_count;
      acc_mul_nxt = 32'd1;
      acc_inc_nxt = 32'd0;
      cur_mul_nxt = lcg_ja_pkg::LCG_MUL;
      cur_inc_nxt = lcg_ja_pkg::LCG_INC;
    end

    if (ctrl.iter) begin
      // fold current jump in when this bit of the count is set
      if (steps_r[0]) begin
        acc_mul_nxt = prod[lcg_ja_pkg::LN_ACC_MUL];
        acc_inc_nxt = prod[lcg_ja_pkg::LN_ACC_INC] + cur_inc_r;
      end
      // double the jump: compose the map with itself
      cur_inc_nxt = prod[lcg_ja_pkg::LN_CUR_INC];
      cur_mul_nxt = prod[lcg_ja_pkg::LN_CUR_MUL];
      steps_nxt   = {1'b0, steps_r[lcg_ja_pkg::WORD_W-1:1]};
    end

    if (ctrl.fin) begin
      res_nxt = prod[lcg_ja_pkg::LN_ACC_MUL] + acc_inc_r;
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    seed_r    <= seed_nxt;
    steps_r   <= steps_nxt;
    acc_mul_r <= acc_mul_nxt;
    acc_inc_r <= acc_inc_nxt;
    cur_mul_r <= cur_mul_nxt;
    cur_inc_r <= cur_inc_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid         = vld_r;
  assign out_advanced_seed = res_r;

endmodule

>>> rtl/lcg_ja_checker.sv
`timescale 1ns / 1ps

module lcg_ja_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_start_seed,
  input  logic [31:0] in_step_count,
  input  logic        out_valid,
  input  logic [31:0] out_advanced_seed
);

  logic accept;
  assign accept = start && !busy;

  // every accepted request yields its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##34 out_valid)
    else $error("result strobe missing 34 cycles after request");

  // no strobe without a request in flight at the right distance
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 34))
    else $error("result strobe without matching request");

  // zero steps returns the seed unchanged
  a_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_step_count == 32'd0) |->
      ##34 (out_advanced_seed == $past(in_start_seed, 34)))
    else $error("zero-step request changed the seed");

  // block is ready again when the result shows
  a_ready_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result strobe is high");

endmodule

bind lcg_jump_ahead lcg_ja_checker u_lcg_ja_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_start_seed     (in_start_seed),
  .in_step_count     (in_step_count),
  .out_valid         (out_valid),
  .out_advanced_seed (out_advanced_seed)
);
